// ----- rtl/scpd_pkg.sv -----
// Shared constants and types for the serial command and packet deframer.
package scpd_pkg;

   // Field widths
   localparam int ByteWidth    = 8;
   localparam int KindWidth    = 3;
   localparam int ValueWidth   = 64;
   localparam int VersionWidth = 16;
   localparam int WindowWidth  = 32;
   localparam int CsrIdxWidth  = 8;

   // Configuration register indexes
   localparam logic [CsrIdxWidth-1:0] CSR_MAC_ADDRESS      = 8'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_FIRMWARE_VERSION = 8'd1;

   localparam logic [VersionWidth-1:0] VERSION_RESET = 16'h0011;

   // Header words, oldest byte in the top position
   localparam logic [WindowWidth-1:0] HDR_PKT  = 32'h504B543E;  // "PKT>"
   localparam logic [WindowWidth-1:0] HDR_MAC  = 32'h4D41433F;  // "MAC?"
   localparam logic [WindowWidth-1:0] HDR_VER  = 32'h5645523F;  // "VER?"
   localparam logic [WindowWidth-1:0] HDR_RDY  = 32'h5244593F;  // "RDY?"
   localparam logic [WindowWidth-1:0] HDR_RSET = 32'h52534554;  // "RSET"

   // Event kinds
   localparam logic [KindWidth-1:0] EV_MAC     = 3'd0;
   localparam logic [KindWidth-1:0] EV_VER     = 3'd1;
   localparam logic [KindWidth-1:0] EV_RDY     = 3'd2;
   localparam logic [KindWidth-1:0] EV_RESET   = 3'd3;
   localparam logic [KindWidth-1:0] EV_PAYLOAD = 3'd4;

   // One result from the parser
   typedef struct packed {
      logic                    present;
      logic [KindWidth-1:0]    event_kind;
      logic [ByteWidth-1:0]    payload_byte;
      logic [ValueWidth-1:0]   reply_value;
      logic                    frame_last;
      logic                    checksum_ok;
   } scpd_result_type;

endpackage

// ----- rtl/serial_command_packet_deframer.sv -----
// Top level of the serial command and packet deframer.
// A byte held in the input register is parsed into the result register.
// Throughput: one byte per cycle unless stalled; the parser state updates once per byte.
// A byte that gives no result moves on even while the result register is stalled.
// Reset (synchronous, active high) empties both registers, returns the parser to header mode
// with a cleared window, and sets the MAC address to 0 and the version to 0x0011.
module serial_command_packet_deframer (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [scpd_pkg::ByteWidth-1:0]       req_rx_byte,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [scpd_pkg::KindWidth-1:0]       rsp_event_kind,
   output logic [scpd_pkg::ByteWidth-1:0]       rsp_payload_byte,
   output logic [scpd_pkg::ValueWidth-1:0]      rsp_reply_value,
   output logic                                 rsp_frame_last,
   output logic                                 rsp_checksum_ok,
   input  logic                                 csr_write_enable,
   input  logic [scpd_pkg::CsrIdxWidth-1:0]     csr_index,
   input  logic [scpd_pkg::ValueWidth-1:0]      csr_write_data
);
   import scpd_pkg::*;

   logic [ValueWidth-1:0]   mac_ff;
   logic [VersionWidth-1:0] version_ff;
   logic                    in_valid_ff;
   logic [ByteWidth-1:0]    in_byte_ff;
   logic                    out_valid_ff;
   scpd_result_type         out_ff;
   scpd_result_type         result;
   logic                    advance;
   logic                    load_out;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mac_ff     <= '0;
         version_ff <= VERSION_RESET;
      end else if (csr_write_enable) begin
         if (csr_index == CSR_MAC_ADDRESS) begin
            mac_ff <= csr_write_data;
         end else if (csr_index == CSR_FIRMWARE_VERSION) begin
            version_ff <= csr_write_data[VersionWidth-1:0];
         end
      end
   end

   scpd_parser u_parser (
      .clock            (clock),
      .reset            (reset),
      .step             (advance),
      .rx_byte          (in_byte_ff),
      .mac_address      (mac_ff),
      .firmware_version (version_ff),
      .result           (result)
   );

   // Stage byte moves on when its result has room, or when it has no result
   assign advance   = in_valid_ff && (!result.present || !out_valid_ff || rsp_ready);
   assign load_out  = advance && result.present;
   assign req_ready = !in_valid_ff || advance;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (load_out) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         out_ff <= result;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_event_kind   = out_ff.event_kind;
   assign rsp_payload_byte = out_ff.payload_byte;
   assign rsp_reply_value  = out_ff.reply_value;
   assign rsp_frame_last   = out_ff.frame_last;
   assign rsp_checksum_ok  = out_ff.checksum_ok;

   // Checks
   a_flags_only_on_payload : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_kind != EV_PAYLOAD) |-> !rsp_frame_last && !rsp_checksum_ok)
      else $error("frame flags set on a reply event");

   a_ok_implies_last : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_checksum_ok |-> rsp_frame_last)
      else $error("checksum ok flagged on a byte that is not last");

   a_payload_no_value : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_kind == EV_PAYLOAD) |-> (rsp_reply_value == '0))
      else $error("reply value set on a payload byte");

   a_stage_holds : assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_byte_ff))
      else $error("stalled input stage lost its byte");

   a_result_kept : assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_ready |=> !load_out || $past(!load_out))
      else $error("result register overwritten while stalled");

endmodule

// ----- rtl/scpd_parser.sv -----
// Header window matcher and frame parser state, one byte per step.
module scpd_parser (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 step,
   input  logic [scpd_pkg::ByteWidth-1:0]       rx_byte,
   input  logic [scpd_pkg::ValueWidth-1:0]      mac_address,
   input  logic [scpd_pkg::VersionWidth-1:0]    firmware_version,
   output scpd_pkg::scpd_result_type            result
);
   import scpd_pkg::*;

   localparam logic [1:0] PHASE_HEADER   = 2'd0;
   localparam logic [1:0] PHASE_LENGTH   = 2'd1;
   localparam logic [1:0] PHASE_PAYLOAD  = 2'd2;
   localparam logic [1:0] PHASE_CHECKSUM = 2'd3;

   logic [1:0]             phase_ff, phase_in;
   logic [WindowWidth-1:0] window_ff, window_in;
   logic [ByteWidth-1:0]   length_ff, length_in;
   logic [ByteWidth-1:0]   expected_ff, expected_in;
   logic [ByteWidth-1:0]   running_ff, running_in;
   logic [ByteWidth-1:0]   seen_ff, seen_in;
   logic [WindowWidth-1:0] shifted;
   logic [ByteWidth-1:0]   xor_next;
   logic [ByteWidth-1:0]   count_next;
   logic                   last;

   assign shifted    = {window_ff[WindowWidth-ByteWidth-1:0], rx_byte};
   assign xor_next   = running_ff ^ rx_byte;
   assign count_next = seen_ff + 8'd1;
   // a length of zero matches after the count wraps past 255
   assign last       = (count_next == length_ff);

   // Next state and the result for the byte at hand
   always_comb begin
      phase_in    = phase_ff;
      window_in   = window_ff;
      length_in   = length_ff;
      expected_in = expected_ff;
      running_in  = running_ff;
      seen_in     = seen_ff;
      result      = '0;
      case (phase_ff)
         PHASE_HEADER: begin
            window_in = shifted;
            if (shifted == HDR_PKT) begin
               phase_in  = PHASE_LENGTH;
               window_in = '0;
            end else if (shifted == HDR_MAC) begin
               result.present     = 1'b1;
               result.event_kind  = EV_MAC;
               result.reply_value = mac_address;
            end else if (shifted == HDR_VER) begin
               result.present     = 1'b1;
               result.event_kind  = EV_VER;
               result.reply_value = {{(ValueWidth-VersionWidth){1'b0}}, firmware_version};
            end else if (shifted == HDR_RDY) begin
               result.present    = 1'b1;
               result.event_kind = EV_RDY;
            end else if (shifted == HDR_RSET) begin
               result.present    = 1'b1;
               result.event_kind = EV_RESET;
            end
         end
         PHASE_LENGTH: begin
            length_in = rx_byte;
            phase_in  = PHASE_CHECKSUM;
         end
         PHASE_CHECKSUM: begin
            expected_in = rx_byte;
            running_in  = '0;
            seen_in     = '0;
            phase_in    = PHASE_PAYLOAD;
         end
         PHASE_PAYLOAD: begin
            running_in          = xor_next;
            seen_in             = count_next;
            result.present      = 1'b1;
            result.event_kind   = EV_PAYLOAD;
            result.payload_byte = rx_byte;
            result.frame_last   = last;
            result.checksum_ok  = last && (xor_next == expected_ff);
            if (last) begin
               phase_in = PHASE_HEADER;
            end
         end
         default: begin
            phase_in = PHASE_HEADER;
         end
      endcase
   end

   // Parser state, advanced once per byte
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PHASE_HEADER;
         window_ff   <= '0;
         length_ff   <= '0;
         expected_ff <= '0;
         running_ff  <= '0;
         seen_ff     <= '0;
      end else if (step) begin
         phase_ff    <= phase_in;
         window_ff   <= window_in;
         length_ff   <= length_in;
         expected_ff <= expected_in;
         running_ff  <= running_in;
         seen_ff     <= seen_in;
      end
   end

endmodule

// ----- dv/serial_command_packet_deframer_tb.sv -----
// Self-checking testbench for the serial command and packet deframer.
module serial_command_packet_deframer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import scpd_pkg::*;

   localparam int StallLimit = 4000;
   localparam int SettleCycles = 6;
   localparam logic [CsrIdxWidth-1:0] CSR_UNUSED = CSR_FIRMWARE_VERSION + 8'd1;

   // Parser phases, encoded as the block keeps them
   typedef enum logic [1:0] {
      PARSE_HEADER   = 2'd0,
      PARSE_LENGTH   = 2'd1,
      PARSE_PAYLOAD  = 2'd2,
      PARSE_CHECKSUM = 2'd3
   } parse_phase_type;

   typedef struct packed {
      logic [KindWidth-1:0]  kind;
      logic [ByteWidth-1:0]  data;
      logic [ValueWidth-1:0] value;
      logic                  last;
      logic                  ok;
   } deframer_event_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [ByteWidth-1:0]   req_rx_byte = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [KindWidth-1:0]   rsp_event_kind;
   logic [ByteWidth-1:0]   rsp_payload_byte;
   logic [ValueWidth-1:0]  rsp_reply_value;
   logic                   rsp_frame_last;
   logic                   rsp_checksum_ok;
   logic                   csr_write_enable = 1'b0;
   logic [CsrIdxWidth-1:0] csr_index = '0;
   logic [ValueWidth-1:0]  csr_write_data = '0;

   // Stimulus and scoreboard state
   logic [ByteWidth-1:0] rx_pending[$];
   deframer_event_type   event_backlog[$];
   int                   queued_bytes = 0;
   int                   mismatches = 0;
   int                   stall_cycles = 0;
   logic                 rx_taken = 1'b0;
   logic                 gap_free = 1'b0;

   // Shadow copy of the parser and its registers
   parse_phase_type         phase = PARSE_HEADER;
   logic [WindowWidth-1:0]  window = '0;
   logic [ByteWidth-1:0]    frame_len = '0;
   logic [ByteWidth-1:0]    sum_wanted = '0;
   logic [ByteWidth-1:0]    frame_sum = '0;
   logic [ByteWidth-1:0]    frame_count = '0;
   logic [ValueWidth-1:0]   mac_copy = '0;
   logic [VersionWidth-1:0] version_copy = VERSION_RESET;

   string header_words[5] = '{"PKT>", "MAC?", "VER?", "RDY?", "RSET"};

   serial_command_packet_deframer uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_event_kind   (rsp_event_kind),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_reply_value  (rsp_reply_value),
      .rsp_frame_last   (rsp_frame_last),
      .rsp_checksum_ok  (rsp_checksum_ok),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   task automatic post_event(input logic [KindWidth-1:0] kind, input logic [ByteWidth-1:0] data,
                             input logic [ValueWidth-1:0] value, input logic last,
                             input logic ok);
      deframer_event_type ev;
      ev = '{kind: kind, data: data, value: value, last: last, ok: ok};
      event_backlog.push_back(ev);
   endtask

   // Advance the shadow parser by one received byte
   task automatic parse_rx_byte(input logic [ByteWidth-1:0] b);
      logic last;
      case (phase)
         PARSE_HEADER: begin
            window = {window[WindowWidth-9:0], b};
            if (window == HDR_PKT) begin
               phase = PARSE_LENGTH;
               window = '0;
            end else if (window == HDR_MAC) begin
               post_event(EV_MAC, '0, mac_copy, 1'b0, 1'b0);
            end else if (window == HDR_VER) begin
               post_event(EV_VER, '0, ValueWidth'(version_copy), 1'b0, 1'b0);
            end else if (window == HDR_RDY) begin
               post_event(EV_RDY, '0, '0, 1'b0, 1'b0);
            end else if (window == HDR_RSET) begin
               post_event(EV_RESET, '0, '0, 1'b0, 1'b0);
            end
         end
         PARSE_LENGTH: begin
            frame_len = b;
            phase = PARSE_CHECKSUM;
         end
         PARSE_CHECKSUM: begin
            sum_wanted = b;
            frame_sum = '0;
            frame_count = '0;
            phase = PARSE_PAYLOAD;
         end
         default: begin
            // count wraps at 8 bits, so a zero length closes after 256 bytes
            frame_sum = frame_sum ^ b;
            frame_count = frame_count + 8'd1;
            last = (frame_count == frame_len);
            post_event(EV_PAYLOAD, b, '0, last, last && (frame_sum == sum_wanted));
            if (last) phase = PARSE_HEADER;
         end
      endcase
   endtask

   task automatic check_field(input string name, input logic [ValueWidth-1:0] want,
                              input logic [ValueWidth-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         mismatches++;
      end
   endtask

   // Monitor: checks result transfers, tracks register writes, predicts per byte transfer
   always @(posedge clock) begin
      deframer_event_type want;
      rx_taken <= !reset && req_valid && req_ready;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (event_backlog.size() == 0) begin
               $display("%0t: unexpected result, actual kind %0h byte %0h value %0h",
                        $time, rsp_event_kind, rsp_payload_byte, rsp_reply_value);
               mismatches++;
            end else begin
               want = event_backlog.pop_front();
               check_field("event_kind", ValueWidth'(want.kind), ValueWidth'(rsp_event_kind));
               check_field("payload_byte", ValueWidth'(want.data),
                           ValueWidth'(rsp_payload_byte));
               check_field("reply_value", want.value, rsp_reply_value);
               check_field("frame_last", ValueWidth'(want.last), ValueWidth'(rsp_frame_last));
               check_field("checksum_ok", ValueWidth'(want.ok), ValueWidth'(rsp_checksum_ok));
            end
         end
         if (csr_write_enable) begin
            case (csr_index)
               CSR_MAC_ADDRESS: mac_copy = csr_write_data;
               CSR_FIRMWARE_VERSION: version_copy = csr_write_data[VersionWidth-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) parse_rx_byte(req_rx_byte);
      end
   end

   // Watchdog: ends the run when no transfer happens for too long
   always @(posedge clock) begin
      if (stall_cycles >= StallLimit) begin
         $display("%0t: no transfer for %0d cycles", $time, StallLimit);
         $display("Regression FAIL");
         $finish;
      end else if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Byte driver: holds a byte until its transfer, with random gaps
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !rx_taken) begin
         // hold until transfer
      end else if (rx_pending.size() != 0 && (gap_free || $urandom_range(99) >= 10)) begin
         req_valid <= 1'b1;
         req_rx_byte <= rx_pending.pop_front();
      end else begin
         req_valid <= 1'b0;
      end
   end

   // Result side back-pressure
   always @(negedge clock) begin
      rsp_ready <= gap_free || ($urandom_range(99) >= 10);
   end

   task automatic push_byte(input logic [ByteWidth-1:0] b);
      rx_pending.push_back(b);
      queued_bytes++;
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) push_byte(s[i]);
   endtask

   // Queue a whole frame; length 0 carries 256 payload bytes
   task automatic push_frame(input logic [ByteWidth-1:0] len, input bit good);
      logic [ByteWidth-1:0] payload[$];
      logic [ByteWidth-1:0] sum;
      int n;
      n = (len == 0) ? 256 : len;
      sum = '0;
      repeat (n) begin
         payload.push_back(ByteWidth'($urandom));
         sum = sum ^ payload[$];
      end
      if (!good) sum = sum ^ (8'd1 << $urandom_range(7));
      push_text(header_words[0]);
      push_byte(len);
      push_byte(sum);
      foreach (payload[i]) push_byte(payload[i]);
   endtask

   // Mostly well-formed commands and frames, some broken headers and noise
   task automatic fill_random(input int goal);
      int stop_at;
      int pick;
      logic [ByteWidth-1:0] len;
      stop_at = queued_bytes + goal;
      while (queued_bytes < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 45) begin
            len = ($urandom_range(7) == 0) ? ByteWidth'($urandom_range(48, 7))
                                           : ByteWidth'($urandom_range(6, 1));
            push_frame(len, $urandom_range(3) != 0);
         end else if (pick < 75) begin
            if ($urandom_range(1)) push_byte(ByteWidth'($urandom));
            push_text(header_words[$urandom_range(4, 1)]);
         end else if (pick < 85) begin
            push_text(header_words[$urandom_range(4)].substr(0, $urandom_range(2)));
            push_byte(ByteWidth'($urandom));
         end else begin
            repeat ($urandom_range(3, 1)) push_byte(ByteWidth'($urandom));
         end
      end
   endtask

   task automatic write_csr(input logic [CsrIdxWidth-1:0] idx,
                            input logic [ValueWidth-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Wait for all bytes to transfer and all results to arrive, then let the pipe settle
   task automatic drain();
      while (rx_pending.size() != 0 || req_valid || event_backlog.size() != 0)
         @(negedge clock);
      repeat (SettleCycles) @(negedge clock);
   endtask

   initial begin
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // Directed: every command at reset values, then a one-byte frame with a bad checksum
      push_text("MAC?VER?RDY?RSET");
      push_text(header_words[0]);
      push_byte(8'h01);
      push_byte(8'h00);
      push_byte(8'hFF);
      drain();

      // All-ones registers, no gaps on either side
      write_csr(CSR_MAC_ADDRESS, '1);
      write_csr(CSR_FIRMWARE_VERSION, 64'h0000_0000_0000_FFFF);
      gap_free <= 1'b1;
      fill_random(150);
      drain();
      gap_free <= 1'b0;

      // Zero registers (version truncated from a wide write), ignored index, 256-byte frame
      write_csr(CSR_MAC_ADDRESS, '0);
      write_csr(CSR_FIRMWARE_VERSION, 64'hFFFF_FFFF_FFFF_0000);
      write_csr(CSR_UNUSED, {$urandom, $urandom});
      push_text("RSETMAC?VER?");
      push_frame(8'd0, 1'b1);
      fill_random(100);
      drain();

      // Random register values
      write_csr(CSR_MAC_ADDRESS, {$urandom, $urandom});
      write_csr(CSR_FIRMWARE_VERSION, {$urandom, $urandom});
      fill_random(100);
      drain();

      if (mismatches == 0 && event_backlog.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/scpd_pkg.sv
rtl/scpd_parser.sv
rtl/serial_command_packet_deframer.sv
dv/serial_command_packet_deframer_tb.sv
